// ===== rtl/pdgb_pkg.sv =====
// Package for the gain-boosted PD axis controller.
// Register indexes, widths and shared types. No dependencies.
package pdgb_pkg;

  localparam int CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_ALPHA       = 3'd2,
    REG_DEAD_BAND   = 3'd3,
    REG_BOOST_THR   = 3'd4,
    REG_BOOST_FAC   = 3'd5,
    REG_MAX_CORR    = 3'd6,
    REG_LAG_COMP    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] deriv_gain;
    logic [15:0]        alpha;
    logic [14:0]        dead_band;
    logic [14:0]        boost_thr;
    logic [15:0]        boost_fac;
    logic [14:0]        max_corr;
    logic [15:0]        lag_comp;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] correction;
    logic signed [15:0] axis_error;
    logic signed [15:0] effective_gain;
    logic               in_dead_band;
    logic               applied;
  } res_t;

endpackage

// ===== rtl/pdgb_regs.sv =====
// APB register file for the gain-boosted PD axis controller.
// Depends on pdgb_pkg.
module pdgb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pdgb_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output pdgb_pkg::cfg_t                cfg
);

  pdgb_pkg::cfg_t cfg_r;
  logic           wr;
  pdgb_pkg::reg_idx_t idx;

  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = pdgb_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{boost_fac: 16'd4096, default: '0};
    end else if (wr) begin
      unique case (idx)
        pdgb_pkg::REG_PROP_GAIN:  cfg_r.prop_gain  <= cfg_pwdata[15:0];
        pdgb_pkg::REG_DERIV_GAIN: cfg_r.deriv_gain <= cfg_pwdata[15:0];
        pdgb_pkg::REG_ALPHA:      cfg_r.alpha      <= cfg_pwdata[15:0];
        pdgb_pkg::REG_DEAD_BAND:  cfg_r.dead_band  <= cfg_pwdata[14:0];
        pdgb_pkg::REG_BOOST_THR:  cfg_r.boost_thr  <= cfg_pwdata[14:0];
        pdgb_pkg::REG_BOOST_FAC:  cfg_r.boost_fac  <= cfg_pwdata[15:0];
        pdgb_pkg::REG_MAX_CORR:   cfg_r.max_corr   <= cfg_pwdata[14:0];
        default:                  cfg_r.lag_comp   <= cfg_pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pdgb_pkg::REG_PROP_GAIN:  cfg_prdata = {16'd0, cfg_r.prop_gain};
      pdgb_pkg::REG_DERIV_GAIN: cfg_prdata = {16'd0, cfg_r.deriv_gain};
      pdgb_pkg::REG_ALPHA:      cfg_prdata = {16'd0, cfg_r.alpha};
      pdgb_pkg::REG_DEAD_BAND:  cfg_prdata = {17'd0, cfg_r.dead_band};
      pdgb_pkg::REG_BOOST_THR:  cfg_prdata = {17'd0, cfg_r.boost_thr};
      pdgb_pkg::REG_BOOST_FAC:  cfg_prdata = {16'd0, cfg_r.boost_fac};
      pdgb_pkg::REG_MAX_CORR:   cfg_prdata = {17'd0, cfg_r.max_corr};
      default:                  cfg_prdata = {16'd0, cfg_r.lag_comp};
    endcase
  end

endmodule

// ===== rtl/pdgb_mac.sv =====
// Shared signed multiply-accumulate unit, one product a cycle, registered.
// Depends on nothing.
module pdgb_mac (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [24:0] a,
  input  logic signed [24:0] b,
  output logic signed [47:0] acc
);

  logic signed [47:0] acc_r;
  logic signed [49:0] prod;

  assign prod = a * b;
  assign acc  = acc_r;

  always_ff @(posedge clk) begin
    if (clr)     acc_r <= '0;
    else if (en) acc_r <= acc_r + prod[47:0];
  end

endmodule

// ===== rtl/pdgb_div.sv =====
// Restoring divider, one quotient bit a cycle: 31-bit by 15-bit unsigned.
// Depends on nothing.
module pdgb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] num,
  input  logic [14:0] den,
  output logic        busy,
  output logic [30:0] quo
);

  logic [30:0] q_r;
  logic [15:0] rem_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [15:0] trial;
  logic [16:0] diff;

  assign trial = {rem_r[14:0], q_r[30]};
  assign diff  = {1'b0, trial} - {2'b0, den};
  assign busy  = busy_r;
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd30;
      q_r    <= num;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (!diff[16]) begin
        rem_r <= diff[15:0];
        q_r   <= {q_r[29:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[29:0], 1'b0};
      end
      if (cnt_r == 5'd0) busy_r <= 1'b0;
      else               cnt_r  <= cnt_r - 5'd1;
    end
  end

endmodule

// ===== rtl/pdgb_seq.sv =====
// Sequencer driving the shared multiply-accumulate and divider units.
// Depends on pdgb_pkg, pdgb_mac, pdgb_div.
module pdgb_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  pdgb_pkg::cfg_t     cfg,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic signed [15:0] tilt,
  input  logic signed [15:0] rate,
  input  logic signed [15:0] target,
  input  logic               samp_valid,
  output logic               out_tvalid,
  input  logic               out_tready,
  output pdgb_pkg::res_t     res
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILT0, S_FILT1, S_FILTW, S_LAG, S_ERR, S_DIVS, S_DIVW, S_GAIN,
    S_GAINW, S_SUM0, S_SUM1, S_CORR, S_OUT
  } state_t;

  state_t             state_r;
  logic signed [23:0] frate_r;
  logic signed [15:0] tilt_r, rate_r, target_r;
  logic signed [20:0] err_r;
  logic [20:0]        abs_r;
  logic [15:0]        mult_r;
  logic signed [15:0] gain_r;
  logic               out_valid_r;
  pdgb_pkg::res_t     res_r;

  logic               mac_clr, mac_en;
  logic signed [24:0] mac_a, mac_b;
  logic signed [47:0] acc;
  logic               div_start, div_busy;
  logic [30:0]        div_num, div_quo;

  logic signed [47:0] acc_rnd16, acc_rnd12, acc_rnd17;
  logic signed [20:0] err_c;
  logic [20:0]        abs_c;
  logic signed [21:0] excess;
  logic [14:0]        exc_cl;
  logic               boost_on;
  logic signed [15:0] corr_c;
  logic signed [16:0] lim;

  pdgb_mac u_mac (
    .clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b), .acc(acc)
  );

  pdgb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(cfg.boost_thr), .busy(div_busy), .quo(div_quo)
  );

  assign acc_rnd16 = (acc + 48'sd32768) >>> 16;
  assign acc_rnd12 = (acc + 48'sd2048) >>> 12;
  assign acc_rnd17 = (acc + 48'sd65536) >>> 17;

  assign err_c = 21'(tilt_r) + acc_rnd12[20:0] - 21'(target_r);
  assign abs_c = err_c[20] ? 21'(-err_c) : err_c;

  assign boost_on = (cfg.boost_fac > 16'd4096) && (cfg.boost_thr != 15'd0);
  assign excess   = $signed({1'b0, abs_r}) - $signed({7'd0, cfg.boost_thr});
  assign exc_cl   = (excess > $signed({7'd0, cfg.boost_thr})) ? cfg.boost_thr
                                                              : excess[14:0];
  assign div_num  = {15'd0, 16'(cfg.boost_fac - 16'd4096)} * {16'd0, exc_cl};

  assign lim    = {2'b0, cfg.max_corr};
  assign corr_c = (acc_rnd17 > 48'(lim))  ? lim[15:0] :
                  (acc_rnd17 < 48'(-lim)) ? 16'(-lim) : acc_rnd17[15:0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign res        = res_r;

  always_comb begin
    mac_clr   = 1'b0;
    mac_en    = 1'b0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE:  mac_clr = 1'b1;
      S_FILT0: begin
        mac_en = 1'b1;
        mac_a  = 25'($signed({1'b0, cfg.alpha}));
        mac_b  = 25'(frate_r);
      end
      S_FILT1: begin
        mac_en = 1'b1;
        mac_a  = 25'($signed(18'h10000 - {2'b0, cfg.alpha}));
        mac_b  = 25'($signed({rate_r, 8'd0}));
      end
      S_FILTW: mac_clr = 1'b1;
      S_LAG: begin
        mac_en = 1'b1;
        mac_a  = 25'(rate_r);
        mac_b  = 25'($signed({1'b0, cfg.lag_comp}));
      end
      S_ERR:  mac_clr = 1'b1;
      S_DIVS: div_start = boost_on && (excess > 22'sd0);
      S_DIVW: ;
      S_GAIN: begin
        mac_en = 1'b1;
        mac_a  = 25'(cfg.prop_gain);
        mac_b  = 25'($signed({1'b0, mult_r}));
      end
      S_GAINW: mac_clr = 1'b1;
      S_SUM0: begin
        mac_en = 1'b1;
        mac_a  = 25'(gain_r);
        mac_b  = $signed({err_r, 4'd0});
      end
      S_SUM1: begin
        mac_en = 1'b1;
        mac_a  = 25'(cfg.deriv_gain);
        mac_b  = 25'(frate_r);
      end
      S_CORR: ;
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frate_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          tilt_r   <= tilt;
          rate_r   <= rate;
          target_r <= target;
          if (samp_valid) state_r <= S_FILT0;
          else begin
            res_r       <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_FILT0: state_r <= S_FILT1;
        S_FILT1: state_r <= S_FILTW;
        S_FILTW: begin
          frate_r <= acc_rnd16[23:0];
          state_r <= S_LAG;
        end
        S_LAG: state_r <= S_ERR;
        S_ERR: begin
          err_r   <= err_c;
          abs_r   <= abs_c;
          mult_r  <= 16'd4096;
          state_r <= S_DIVS;
          if (abs_c < {6'd0, cfg.dead_band}) begin
            res_r.correction     <= '0;
            res_r.axis_error     <= (err_c > 21'sd32767) ? 16'sh7fff :
                                    (err_c < -21'sd32768) ? 16'sh8000 : err_c[15:0];
            res_r.effective_gain <= cfg.prop_gain;
            res_r.in_dead_band   <= 1'b1;
            res_r.applied        <= 1'b1;
            out_valid_r          <= 1'b1;
            state_r              <= S_OUT;
          end
        end
        S_DIVS: state_r <= S_DIVW;
        S_DIVW: if (!div_busy) begin
          if (boost_on && (excess > 22'sd0)) mult_r <= 16'(16'd4096 + div_quo[15:0]);
          state_r <= S_GAIN;
        end
        S_GAIN: state_r <= S_GAINW;
        S_GAINW: begin
          gain_r  <= (acc_rnd12 > 48'sd32767) ? 16'sh7fff :
                     (acc_rnd12 < -48'sd32768) ? 16'sh8000 : acc_rnd12[15:0];
          state_r <= S_SUM0;
        end
        S_SUM0: state_r <= S_SUM1;
        S_SUM1: state_r <= S_CORR;
        S_CORR: begin
          res_r.correction     <= corr_c;
          res_r.axis_error     <= (err_r > 21'sd32767) ? 16'sh7fff :
                                  (err_r < -21'sd32768) ? 16'sh8000 : err_r[15:0];
          res_r.effective_gain <= gain_r;
          res_r.in_dead_band   <= 1'b0;
          res_r.applied        <= 1'b1;
          out_valid_r          <= 1'b1;
          state_r              <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pd_axis_controller_gain_boost.sv =====
// Gain-boosted PD balance controller for one axis, top level.
// Invalid words go straight to the result; deadband words end after the error
// step; others run the gain and sum steps, boosted ones after the 31-step divider.
// One word at a time: in_tready returns in the cycle after the result word is taken.
// Reset (rst_n, synchronous): registers to defaults, filtered rate cleared.
// Depends on pdgb_pkg, pdgb_regs, pdgb_seq.
module pd_axis_controller_gain_boost (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [47:0]                   in_tdata,  // tilt_angle, tilt_rate, target_angle
  input  logic                          in_tuser,  // sample_valid
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [47:0]                   out_tdata, // correction, axis_error, effective_gain
  output logic [1:0]                    out_tuser, // in_dead_band, applied
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pdgb_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  pdgb_pkg::cfg_t cfg;
  pdgb_pkg::res_t res;

  assign cfg_pready = 1'b1;

  pdgb_regs u_regs (
    .clk(clk), .rst_n(rst_n), .cfg_psel(cfg_psel), .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg(cfg)
  );

  pdgb_seq u_seq (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_tvalid(in_tvalid),
    .in_tready(in_tready), .tilt(in_tdata[15:0]), .rate(in_tdata[31:16]),
    .target(in_tdata[47:32]), .samp_valid(in_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .res(res)
  );

  assign out_tdata = {res.effective_gain, res.axis_error, res.correction};
  assign out_tuser = {res.applied, res.in_dead_band};

endmodule

// ===== rtl/pdgb_checker.sv =====
// Port-level checker for the PD axis controller, bound to the top level.
// Depends on pd_axis_controller_gain_boost.
module pdgb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == 48'd0 && !out_tuser[0])
    else $error("invalid word not zero");

  a_db_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[15:0] == 16'd0)
    else $error("deadband correction not zero");

endmodule

bind pd_axis_controller_gain_boost pdgb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

// ===== bench/pd_axis_controller_gain_boost_tb.sv =====
// Testbench for the gain-boosted PD axis controller: directed and random words,
// random idling on both sides, results checked against an in-bench predictor.
// Depends on pdgb_pkg and pd_axis_controller_gain_boost.
module pd_axis_controller_gain_boost_tb;

  typedef struct packed {
    logic signed [15:0] tilt;
    logic signed [15:0] rate;
    logic signed [15:0] target;
    logic               sample_ok;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [pdgb_pkg::CfgAddrW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pd_axis_controller_gain_boost uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // controller copy
  logic signed [15:0] kp_r, kd_r;
  logic [15:0] alpha_r, bfac_r, lag_r;
  logic [14:0] dband_r, bthr_r, maxc_r;
  longint      frate;

  sample_t        pending_words[$];
  pdgb_pkg::res_t expected_res[$];
  int             errors = 0;
  bit             stall_go = 0;
  bit             hold_off = 0;

  function automatic longint rnd_shift(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint sat_word(longint x);
    return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
  endfunction

  function automatic pdgb_pkg::res_t predict_correction(sample_t s);
    pdgb_pkg::res_t r;
    longint err, aerr, gain, sum, corr, m, excess;
    r = '0;
    if (!s.sample_ok) return r;
    frate = rnd_shift(longint'(alpha_r) * frate
                      + (65536 - longint'(alpha_r)) * (longint'(s.rate) * 256), 16);
    err = longint'(s.tilt) + rnd_shift(longint'(s.rate) * longint'(lag_r), 12)
          - longint'(s.target);
    aerr = err < 0 ? -err : err;
    if (aerr < longint'(dband_r)) begin
      r.in_dead_band = 1'b1;
      gain = kp_r;
      corr = 0;
    end else begin
      m = 4096;
      excess = aerr - longint'(bthr_r);
      if (bfac_r > 4096 && bthr_r != 0 && excess > 0) begin
        if (excess > longint'(bthr_r)) excess = longint'(bthr_r);
        m = 4096 + ((longint'(bfac_r) - 4096) * excess) / longint'(bthr_r);
      end
      gain = sat_word(rnd_shift(longint'(kp_r) * m, 12));
      sum = gain * err * 16 + longint'(kd_r) * frate;
      corr = rnd_shift(sum, 17);
      if (corr > longint'(maxc_r)) corr = maxc_r;
      if (corr < -longint'(maxc_r)) corr = -longint'(maxc_r);
    end
    r.correction = corr[15:0];
    r.axis_error = 16'(sat_word(err));
    r.effective_gain = gain[15:0];
    r.applied = 1'b1;
    return r;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (in_tvalid && in_tready) expected_res.push_back(predict_correction(
        sample_t'({in_tdata[15:0], in_tdata[31:16], in_tdata[47:32], in_tuser})));
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        sample_t s;
        s = pending_words.pop_front();
        in_tdata <= {s.target, s.rate, s.tilt};
        in_tuser <= s.sample_ok;
        in_tvalid <= 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (stall_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      pdgb_pkg::res_t got, want;
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser[0], out_tuser[1]};
      if (expected_res.size() == 0) begin
        $error("result word with none expected");
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (got.correction !== want.correction) begin
          $error("correction exp %0d got %0d", want.correction, got.correction); errors++;
        end
        if (got.axis_error !== want.axis_error) begin
          $error("axis_error exp %0d got %0d", want.axis_error, got.axis_error); errors++;
        end
        if (got.effective_gain !== want.effective_gain) begin
          $error("effective_gain exp %0d got %0d", want.effective_gain,
                 got.effective_gain); errors++;
        end
        if (got.in_dead_band !== want.in_dead_band) begin
          $error("in_dead_band exp %0b got %0b", want.in_dead_band, got.in_dead_band);
          errors++;
        end
        if (got.applied !== want.applied) begin
          $error("applied exp %0b got %0b", want.applied, got.applied); errors++;
        end
      end
      out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("pd_axis_controller_gain_boost verification failed");
      $finish;
    end
  end

  task automatic reg_write(pdgb_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= pdgb_pkg::CfgAddrW'(4 * int'(idx)); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      pdgb_pkg::REG_PROP_GAIN:  kp_r = val[15:0];
      pdgb_pkg::REG_DERIV_GAIN: kd_r = val[15:0];
      pdgb_pkg::REG_ALPHA:      alpha_r = val[15:0];
      pdgb_pkg::REG_DEAD_BAND:  dband_r = val[14:0];
      pdgb_pkg::REG_BOOST_THR:  bthr_r = val[14:0];
      pdgb_pkg::REG_BOOST_FAC:  bfac_r = val[15:0];
      pdgb_pkg::REG_MAX_CORR:   maxc_r = val[14:0];
      default:                  lag_r = val[15:0];
    endcase
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (pending_words.size() > 0 || in_tvalid || expected_res.size() > 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] kp, logic [15:0] kd, logic [15:0] al,
                         logic [14:0] db, logic [14:0] bt, logic [15:0] bf,
                         logic [14:0] mc, logic [15:0] lg);
    reg_write(pdgb_pkg::REG_PROP_GAIN, kp);  reg_write(pdgb_pkg::REG_DERIV_GAIN, kd);
    reg_write(pdgb_pkg::REG_ALPHA, al);      reg_write(pdgb_pkg::REG_DEAD_BAND, db);
    reg_write(pdgb_pkg::REG_BOOST_THR, bt);  reg_write(pdgb_pkg::REG_BOOST_FAC, bf);
    reg_write(pdgb_pkg::REG_MAX_CORR, mc);   reg_write(pdgb_pkg::REG_LAG_COMP, lg);
  endtask

  function automatic sample_t rand_sample(int span);
    sample_t s;
    s.tilt = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    s.rate = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    s.target = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    s.sample_ok = $urandom_range(0, 7) != 0;
    return s;
  endfunction

  initial begin
    kp_r = 0; kd_r = 0; alpha_r = 0; dband_r = 0; bthr_r = 0;
    bfac_r = 4096; maxc_r = 0; lag_r = 0; frate = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // defaults in force
    pending_words.push_back('{16'sd1000, -16'sd500, 16'sd0, 1'b1});
    drain_all();
    set_all(16'sd2560, -16'sd300, 16'd40000, 15'd200, 15'd1000, 16'd12288,
            15'd8000, 16'd3000);
    pending_words.push_back('{16'sh7fff, 16'sh7fff, -16'sh8000, 1'b1});
    pending_words.push_back('{-16'sh8000, -16'sh8000, 16'sh7fff, 1'b1});
    pending_words.push_back('{16'sd50, 16'sd0, 16'sd0, 1'b1});      // deadband
    pending_words.push_back('{16'sd1500, 16'sd0, 16'sd0, 1'b1});    // mid ramp
    pending_words.push_back('{16'sd1000, 16'sd0, 16'sd0, 1'b1});    // at threshold
    pending_words.push_back('{16'sd3000, 16'sd0, 16'sd0, 1'b1});    // beyond twice
    pending_words.push_back('{-16'sd1700, 16'sd40, 16'sd100, 1'b1});
    pending_words.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0}); // invalid
    drain_all();
    set_all(16'sh7fff, 16'sh7fff, 16'hffff, 15'd0, 15'h7fff, 16'hffff,
            15'h7fff, 16'hffff);
    pending_words.push_back('{16'sh7fff, 16'sh7fff, -16'sh8000, 1'b1});
    pending_words.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1});
    pending_words.push_back('{-16'sd20000, -16'sd9000, 16'sd20000, 1'b1});
    drain_all();
    set_all(-16'sh8000, -16'sh8000, 16'd0, 15'h7fff, 15'd1, 16'd4096, 15'd0, 16'd0);
    pending_words.push_back('{16'sd5, 16'sd5, 16'sd5, 1'b1});
    pending_words.push_back('{-16'sh8000, 16'sd0, 16'sh7fff, 1'b1});
    drain_all();
    // random phases with random settings
    for (int ph = 0; ph < 7; ph++) begin
      set_all(16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom_range(0, 600)),
              15'($urandom_range(0, 2000)), 16'($urandom_range(2000, 20000)),
              15'($urandom), 16'($urandom));
      if (ph == 2) stall_go = 1;
      for (int i = 0; i < 100; i++)
        pending_words.push_back(rand_sample(($urandom_range(0, 3) == 0) ? 0 : 4000));
      drain_all();
    end
    if (errors == 0 && expected_res.size() == 0)
      $display("pd_axis_controller_gain_boost verification clean");
    else
      $display("pd_axis_controller_gain_boost verification failed");
    $finish;
  end
endmodule
